>>> sv/lpcd_pkg.sv
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants of the page cache directory: operation codes,
// field widths, the queued item and the queue status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcd_pkg;

   localparam int MODE_W      = 2;
   localparam int FILE_ID_W   = 2;
   localparam int PAGE_W      = 20;
   localparam int COUNT_W     = 21;
   localparam int SLOT_OUT_W  = 3;
   localparam int TOTAL_W     = 32;
   localparam int STAMP_W     = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [MODE_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_OPEN  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [FILE_ID_W-1:0]   fid;
      logic [PAGE_W-1:0]      page;
      logic [COUNT_W-1:0]     count;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

`default_nettype wire

>>> sv/lpcd_front.sv
// ----------------------------------------------------------------------------
// lpcd_front
// Accept side: take an item when the queue has room, decode the operation
// and fold the file number into the configured file range.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_front
   import lpcd_pkg::*;
#(
   parameter int FILES = 4
) (
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [FILE_ID_W-1:0] req_file_id,
   input  wire logic [PAGE_W-1:0]    req_page_id,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire queue_stat_type       q_stat,
   output logic                      push,
   output item_type                  push_item
);

   int fid_work;

   // fold the file number: at most three subtractions for a two-bit id
   always_comb begin
      fid_work = int'(req_file_id);
      for (int k = 0; k < 3; k++) begin
         if (fid_work >= FILES) begin
            fid_work = fid_work - FILES;
         end
      end
   end

   always_comb begin
      push_item.op    = op_type'(req_mode);
      push_item.fid   = fid_work[FILE_ID_W-1:0];
      push_item.page  = req_page_id;
      push_item.count = req_page_count;
   end

   assign busy = q_stat.full;
   assign push = start && !q_stat.full;

endmodule

`default_nettype wire

>>> sv/lpcd_queue.sv
// ----------------------------------------------------------------------------
// lpcd_queue
// Two-entry item queue between the accept side and the directory engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_queue
   import lpcd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      pop_item,
   output queue_stat_type q_stat
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

>>> sv/lpcd_back.sv
// ----------------------------------------------------------------------------
// lpcd_back
// Directory engine: slot tags and stamps, file end table, victim scan and
// result registers. One item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_back
   import lpcd_pkg::*;
#(
   parameter int SLOTS = 8,
   parameter int FILES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire queue_stat_type        q_stat,
   output logic                       pop,
   input  wire item_type              pop_item,
   output logic                       rsp_strobe,
   output logic                       rsp_status,
   output logic                       rsp_hit,
   output logic [SLOT_OUT_W-1:0]      rsp_slot,
   output logic [COUNT_W-1:0]         rsp_end_page,
   output logic [TOTAL_W-1:0]         rsp_reads_done,
   output logic [TOTAL_W-1:0]         rsp_writes_done
);

   localparam int SW = $clog2(SLOTS);
   localparam int FW = (FILES > 1) ? $clog2(FILES) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_SCAN, ST_FILL} state_type;

   // slot directory
   logic [STAMP_W-1:0]   stamp_ff [SLOTS];
   logic [FILE_ID_W-1:0] owner_ff [SLOTS];
   logic [PAGE_W-1:0]    page_ff  [SLOTS];

   // file end table, valid bits stand for the cleared state
   logic [COUNT_W-1:0]   end_mem [FILES];
   logic                 end_vld_ff [FILES];
   logic [COUNT_W-1:0]   end_rd_ff;
   logic                 end_rd_vld_ff;

   state_type            state_ff, state_in;
   item_type             cur_ff, cur_in;
   logic [STAMP_W-1:0]   use_clock_ff, use_clock_in;
   logic [TOTAL_W-1:0]   read_total_ff, read_total_in;
   logic [TOTAL_W-1:0]   write_total_ff, write_total_in;
   logic [SW-1:0]        scan_idx_ff, scan_idx_in;
   logic [SW-1:0]        best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0]   best_stamp_ff, best_stamp_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]   rsp_end_ff, rsp_end_in;
   logic [TOTAL_W-1:0]   rsp_reads_ff, rsp_reads_in;
   logic [TOTAL_W-1:0]   rsp_writes_ff, rsp_writes_in;

   logic [SLOTS-1:0]     own_hit, tag_hit, tag_first, empty_vec, clr_vec;
   logic [SW-1:0]        hit_idx, empty_idx;
   logic [COUNT_W-1:0]   end_cur, end_bump;
   logic                 past_end;
   logic [STAMP_W-1:0]   stamp_next, scan_stamp;

   logic                 stamp_we, fill_we, mem_we;
   logic [SW-1:0]        stamp_wa;
   logic [COUNT_W-1:0]   mem_wd;
   logic [FW-1:0]        mem_wa, rd_a;

   // tag compare across all slots
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         empty_vec[i] = (stamp_ff[i] == '0);
         own_hit[i]   = !empty_vec[i] && (owner_ff[i] == cur_ff.fid);
         tag_hit[i]   = own_hit[i] && (page_ff[i] == cur_ff.page);
      end
   end

   assign tag_first = tag_hit & (~tag_hit + 1'b1);

   // lowest-numbered hit and lowest-numbered empty slot
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (tag_hit[i]) begin
            hit_idx = SW'(i);
         end
         if (empty_vec[i]) begin
            empty_idx = SW'(i);
         end
      end
   end

   assign end_cur    = end_rd_vld_ff ? end_rd_ff : '0;
   assign past_end   = ({1'b0, cur_ff.page} >= end_cur);
   assign end_bump   = past_end ? ({1'b0, cur_ff.page} + 1'b1) : end_cur;
   assign stamp_next = use_clock_ff + 1'b1;
   assign scan_stamp = stamp_ff[scan_idx_ff];
   assign mem_wa     = FW'(cur_ff.fid);
   assign rd_a       = FW'(pop_item.fid);

   always_comb begin
      state_in       = state_ff;
      pop            = 1'b0;
      cur_in         = cur_ff;
      use_clock_in   = use_clock_ff;
      read_total_in  = read_total_ff;
      write_total_in = write_total_ff;
      scan_idx_in    = scan_idx_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_reads_in   = rsp_reads_ff;
      rsp_writes_in  = rsp_writes_ff;
      stamp_we       = 1'b0;
      fill_we        = 1'b0;
      stamp_wa       = hit_idx;
      mem_we         = 1'b0;
      mem_wd         = '0;
      clr_vec        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               cur_in   = pop_item;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = 1'b0;
            rsp_hit_in    = 1'b0;
            rsp_slot_in   = '0;
            rsp_end_in    = end_cur;
            rsp_reads_in  = read_total_ff;
            rsp_writes_in = write_total_ff;
            state_in      = ST_IDLE;
            unique case (cur_ff.op)
               OP_READ: begin
                  priority if (past_end) begin
                     rsp_status_in = 1'b1;
                  end else if (|tag_hit) begin
                     stamp_we     = 1'b1;
                     stamp_wa     = hit_idx;
                     use_clock_in = stamp_next;
                     rsp_hit_in   = 1'b1;
                     rsp_slot_in  = SLOT_OUT_W'(hit_idx);
                  end else if (|empty_vec) begin
                     stamp_we      = 1'b1;
                     fill_we       = 1'b1;
                     stamp_wa      = empty_idx;
                     use_clock_in  = stamp_next;
                     read_total_in = read_total_ff + 1'b1;
                     rsp_slot_in   = SLOT_OUT_W'(empty_idx);
                     rsp_reads_in  = read_total_ff + 1'b1;
                  end else begin
                     // directory full: hold the result, scan for the oldest stamp
                     rsp_strobe_in = 1'b0;
                     best_idx_in   = '0;
                     best_stamp_in = stamp_ff[0];
                     scan_idx_in   = SW'(1);
                     state_in      = ST_SCAN;
                  end
               end
               OP_WRITE: begin
                  clr_vec        = tag_first;
                  mem_we         = 1'b1;
                  mem_wd         = end_bump;
                  rsp_end_in     = end_bump;
                  write_total_in = write_total_ff + 1'b1;
                  rsp_writes_in  = write_total_ff + 1'b1;
               end
               OP_OPEN: begin
                  mem_we     = 1'b1;
                  mem_wd     = cur_ff.count;
                  rsp_end_in = cur_ff.count;
               end
               OP_CLOSE: begin
                  clr_vec    = own_hit;
                  mem_we     = 1'b1;
                  mem_wd     = '0;
                  rsp_end_in = '0;
               end
               default: begin
                  rsp_status_in = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_stamp < best_stamp_ff) begin
               best_idx_in   = scan_idx_ff;
               best_stamp_in = scan_stamp;
            end
            if (scan_idx_ff == SW'(SLOTS - 1)) begin
               state_in = ST_FILL;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_FILL: begin
            stamp_we      = 1'b1;
            fill_we       = 1'b1;
            stamp_wa      = best_idx_ff;
            use_clock_in  = stamp_next;
            read_total_in = read_total_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_status_in = 1'b0;
            rsp_hit_in    = 1'b0;
            rsp_slot_in   = SLOT_OUT_W'(best_idx_ff);
            rsp_end_in    = end_cur;
            rsp_reads_in  = read_total_ff + 1'b1;
            rsp_writes_in = write_total_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, counters and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         use_clock_ff   <= STAMP_W'(1);
         read_total_ff  <= '0;
         write_total_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_ff         <= cur_in;
         use_clock_ff   <= use_clock_in;
         read_total_ff  <= read_total_in;
         write_total_ff <= write_total_in;
         scan_idx_ff    <= scan_idx_in;
         best_idx_ff    <= best_idx_in;
         best_stamp_ff  <= best_stamp_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_end_ff     <= rsp_end_in;
         rsp_reads_ff   <= rsp_reads_in;
         rsp_writes_ff  <= rsp_writes_in;
      end
   end

   // stamps double as slot valid: zero means empty
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (clr_vec[i]) begin
               stamp_ff[i] <= '0;
            end
            if (stamp_we && (stamp_wa == SW'(i))) begin
               stamp_ff[i] <= stamp_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         owner_ff[stamp_wa] <= cur_ff.fid;
         page_ff[stamp_wa]  <= cur_ff.page;
      end
   end

   // file end table: one write port, registered read on pop
   always_ff @(posedge clock) begin
      if (mem_we) begin
         end_mem[mem_wa] <= mem_wd;
      end
      if (pop) begin
         end_rd_ff <= end_mem[rd_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < FILES; f++) begin
            end_vld_ff[f] <= 1'b0;
         end
         end_rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            end_vld_ff[mem_wa] <= 1'b1;
         end
         if (pop) begin
            end_rd_vld_ff <= end_vld_ff[rd_a];
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_end_page    = rsp_end_ff;
   assign rsp_reads_done  = rsp_reads_ff;
   assign rsp_writes_done = rsp_writes_ff;

endmodule

`default_nettype wire

>>> sv/lru_page_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// lru_page_cache_directory_unit
// Tag directory of a shared, fully associative page read cache with
// timestamp LRU replacement, for reads, writes, opens and closes of pages.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive start with req_mode, req_file_id, req_page_id and
//   req_page_count; the item is taken at a clock edge where start is high
//   and busy is low. busy rises while the two-entry item queue is full.
//   Result side: one item per request, shown for exactly one cycle with
//   rsp_strobe high. The receiver cannot hold results off and has no need
//   to: the result registers are written only once per item.
//   Path: every item passes through the item queue, the engine's pop step
//   and its lookup step, which loads the result registers; a read miss on a
//   full directory goes on to the oldest-stamp scan (one slot compared per
//   cycle) and the refill step, which loads the result registers instead.
//   The engine takes one item at a time: it pops the next item only once
//   the lookup step, or the scan and refill of such a miss, is done.
//   Reset: synchronous, active high. Empties every slot, clears the file
//   end table, sets the stamp clock to one and zeroes both totals. No
//   clearing pass follows: the block takes items in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_cache_directory_unit
   import lpcd_pkg::*;
#(
   parameter int SLOTS = 8,
   parameter int FILES = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [FILE_ID_W-1:0] req_file_id,
   input  wire logic [PAGE_W-1:0]    req_page_id,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic                      rsp_hit,
   output logic [SLOT_OUT_W-1:0]     rsp_slot,
   output logic [COUNT_W-1:0]        rsp_end_page,
   output logic [TOTAL_W-1:0]        rsp_reads_done,
   output logic [TOTAL_W-1:0]        rsp_writes_done
);

   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   item_type       push_item;
   item_type       pop_item;

   // accept and decode; fold the file number into range
   lpcd_front #(
      .FILES (FILES)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_file_id    (req_file_id),
      .req_page_id    (req_page_id),
      .req_page_count (req_page_count),
      .q_stat         (q_stat),
      .push           (push),
      .push_item      (push_item)
   );

   // decouple the accept side from the engine
   lpcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   // carry out each item against the directory and file end table
   lpcd_back #(
      .SLOTS (SLOTS),
      .FILES (FILES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .pop             (pop),
      .pop_item        (pop_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_end_page    (rsp_end_page),
      .rsp_reads_done  (rsp_reads_done),
      .rsp_writes_done (rsp_writes_done)
   );

endmodule

`default_nettype wire

>>> sv/lpcd_checker.sv
// ----------------------------------------------------------------------------
// lpcd_checker
// Port-level checks of the page cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_checker
   import lpcd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_strobe,
   input wire logic                  rsp_status,
   input wire logic                  rsp_hit,
   input wire logic [SLOT_OUT_W-1:0] rsp_slot
);

   // the engine needs a pop step between results
   a_strobe_spaced : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("result or busy right after reset");

   a_fail_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (!rsp_hit && (rsp_slot == '0)))
      else $error("failed read reports a hit or slot");

   // the queue only fills through an accepted item
   a_busy_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted item");

endmodule

bind lru_page_cache_directory_unit lpcd_checker u_lpcd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_hit    (rsp_hit),
   .rsp_slot   (rsp_slot)
);

`default_nettype wire

>>> tb/lpcd_checker.sv
// ----------------------------------------------------------------------------
// lpcd_tb_checker
// Watches the request and result channels of the page cache directory. It
// keeps its own copy of the slot tags, stamps, file end pages and totals,
// works out the reply owed for every accepted item and compares each reply
// shown on the result ports, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module lpcd_tb_checker
   import lpcd_pkg::*;
#(
   parameter int SLOTS = 8,
   parameter int FILES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [FILE_ID_W-1:0]  req_file_id,
   input  logic [PAGE_W-1:0]     req_page_id,
   input  logic [COUNT_W-1:0]    req_page_count,
   input  logic                  rsp_strobe,
   input  logic                  rsp_status,
   input  logic                  rsp_hit,
   input  logic [SLOT_OUT_W-1:0] rsp_slot,
   input  logic [COUNT_W-1:0]    rsp_end_page,
   input  logic [TOTAL_W-1:0]    rsp_reads_done,
   input  logic [TOTAL_W-1:0]    rsp_writes_done,
   output int                    fail_count,
   output int                    replies_owed
);

   typedef struct packed {
      logic                  status;
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic [COUNT_W-1:0]    end_page;
      logic [TOTAL_W-1:0]    reads;
      logic [TOTAL_W-1:0]    writes;
   } dir_reply_type;

   logic [FILE_ID_W-1:0] tag_owner [SLOTS];
   logic [PAGE_W-1:0]    tag_page  [SLOTS];
   logic [STAMP_W-1:0]   tag_stamp [SLOTS];
   logic [STAMP_W-1:0]   stamp_clock;
   logic [COUNT_W-1:0]   end_of_file [FILES];
   logic [TOTAL_W-1:0]   miss_total;
   logic [TOTAL_W-1:0]   write_total;

   dir_reply_type replies_due [$];
   dir_reply_type want;
   int            items_seen;

   initial begin
      fail_count   = 0;
      replies_owed = 0;
      items_seen   = 0;
   end

   task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got,
                                  logic [TOTAL_W-1:0] exp_val);
      fail_count++;
      $display("mismatch after %0d items: %s got %0h, expected %0h",
               items_seen, what, got, exp_val);
   endtask

   // Apply one operation to the shadow directory and return the reply it owes.
   function automatic dir_reply_type apply_page_op(op_type op,
                                                   logic [FILE_ID_W-1:0] fid_in,
                                                   logic [PAGE_W-1:0] page,
                                                   logic [COUNT_W-1:0] count);
      dir_reply_type r;
      int            f;
      int            found;
      int            victim;
      r = '0;
      f = int'(fid_in) % FILES;
      case (op)
         OP_READ: begin
            if ({1'b0, page} >= end_of_file[f]) begin
               r.status = 1'b1;
            end else begin
               found = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (tag_stamp[i] != 0 && tag_owner[i] == f && tag_page[i] == page) begin
                     found = i;
                     break;
                  end
               end
               if (found >= 0) begin
                  stamp_clock      = stamp_clock + STAMP_W'(1);
                  tag_stamp[found] = stamp_clock;
                  r.hit            = 1'b1;
                  r.slot           = SLOT_OUT_W'(found);
               end else begin
                  // first empty slot, else lowest-numbered oldest stamp
                  victim = 0;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (tag_stamp[i] == 0) begin
                        victim = i;
                        break;
                     end
                     if (tag_stamp[i] < tag_stamp[victim])
                        victim = i;
                  end
                  stamp_clock       = stamp_clock + STAMP_W'(1);
                  tag_owner[victim] = FILE_ID_W'(f);
                  tag_page[victim]  = page;
                  tag_stamp[victim] = stamp_clock;
                  r.slot            = SLOT_OUT_W'(victim);
                  miss_total        = miss_total + TOTAL_W'(1);
               end
            end
         end
         OP_WRITE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tag_stamp[i] != 0 && tag_owner[i] == f && tag_page[i] == page) begin
                  tag_owner[i] = '0;
                  tag_page[i]  = '0;
                  tag_stamp[i] = '0;
                  break;
               end
            end
            if ({1'b0, page} >= end_of_file[f])
               end_of_file[f] = {1'b0, page} + 1'b1;
            write_total = write_total + TOTAL_W'(1);
         end
         OP_OPEN: begin
            end_of_file[f] = count;
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tag_stamp[i] != 0 && tag_owner[i] == f) begin
                  tag_owner[i] = '0;
                  tag_page[i]  = '0;
                  tag_stamp[i] = '0;
               end
            end
            end_of_file[f] = '0;
         end
      endcase
      r.end_page = end_of_file[f];
      r.reads    = miss_total;
      r.writes   = write_total;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tag_owner[i] = '0;
            tag_page[i]  = '0;
            tag_stamp[i] = '0;
         end
         for (int i = 0; i < FILES; i++)
            end_of_file[i] = '0;
         stamp_clock = STAMP_W'(1);
         miss_total  = '0;
         write_total = '0;
         replies_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", TOTAL_W'(rsp_status), TOTAL_W'(want.status));
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", TOTAL_W'(rsp_hit), TOTAL_W'(want.hit));
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", TOTAL_W'(rsp_slot), TOTAL_W'(want.slot));
               if (rsp_end_page !== want.end_page)
                  report_mismatch("end_page", TOTAL_W'(rsp_end_page),
                                  TOTAL_W'(want.end_page));
               if (rsp_reads_done !== want.reads)
                  report_mismatch("reads_done", rsp_reads_done, want.reads);
               if (rsp_writes_done !== want.writes)
                  report_mismatch("writes_done", rsp_writes_done, want.writes);
            end
         end
         if (start && !busy) begin
            replies_due.push_back(apply_page_op(op_type'(req_mode), req_file_id,
                                                req_page_id, req_page_count));
            items_seen++;
         end
      end
      replies_owed = replies_due.size();
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the page cache directory. A directed opening
// covers field extremes, every operation, full-directory eviction, write
// invalidation and repeated open and close; a long random run of mostly
// well-formed page traffic on small files follows. A checker beside the
// block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;
   import lpcd_pkg::*;

   localparam int SLOTS        = 8;
   localparam int FILES        = 4;
   localparam int RANDOM_ITEMS = 1250;
   // generous: far more than the run needs, even if every item met a
   // full-directory miss and the longest idle gap of the sender
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [FILE_ID_W-1:0]  req_file_id = '0;
   logic [PAGE_W-1:0]     req_page_id = '0;
   logic [COUNT_W-1:0]    req_page_count = '0;
   logic                  rsp_strobe;
   logic                  rsp_status;
   logic                  rsp_hit;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [COUNT_W-1:0]    rsp_end_page;
   logic [TOTAL_W-1:0]    rsp_reads_done;
   logic [TOTAL_W-1:0]    rsp_writes_done;

   int   fail_count;
   int   replies_owed;
   int   cycle_count = 0;
   logic req_taken = 1'b0;
   bit   no_idle = 1'b0;
   // rough idea of each file's length, only to aim reads near real pages
   int   file_span [FILES];

   lru_page_cache_directory_unit #(.SLOTS(SLOTS), .FILES(FILES)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_file_id     (req_file_id),
      .req_page_id     (req_page_id),
      .req_page_count  (req_page_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_end_page    (rsp_end_page),
      .rsp_reads_done  (rsp_reads_done),
      .rsp_writes_done (rsp_writes_done)
   );

   lpcd_tb_checker #(.SLOTS(SLOTS), .FILES(FILES)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_file_id     (req_file_id),
      .req_page_id     (req_page_id),
      .req_page_count  (req_page_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_end_page    (rsp_end_page),
      .rsp_reads_done  (rsp_reads_done),
      .rsp_writes_done (rsp_writes_done),
      .fail_count      (fail_count),
      .replies_owed    (replies_owed)
   );

   always #5 clock = ~clock;

   // Record at the rising edge whether the item on the request ports was
   // taken; the driver reads this at the following falling edge.
   always @(posedge clock)
      req_taken <= !reset && start && !busy;

   // Hold one item on the request ports until the block takes it. Idle for
   // a random gap first unless a no-idle stretch is running. Returns
   // at the falling edge after acceptance with start still high, so a
   // back-to-back item keeps start up without a glitch.
   task automatic issue_op(op_type op, logic [FILE_ID_W-1:0] fid,
                           logic [PAGE_W-1:0] page, logic [COUNT_W-1:0] count);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, 4));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       <= op;
      req_file_id    <= fid;
      req_page_id    <= page;
      req_page_count <= count;
      start          <= 1'b1;
      do @(negedge clock); while (!req_taken);
      case (op)
         OP_OPEN:  file_span[fid] = int'(count);
         OP_WRITE: if (int'(page) >= file_span[fid]) file_span[fid] = int'(page) + 1;
         OP_CLOSE: file_span[fid] = 0;
         default: ;
      endcase
   endtask

   // Watchdog: end the run as a failure if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int          pick;
      int          span;
      int          reach;
      op_type      op;
      logic [1:0]  fid;
      logic [19:0] page;
      logic [20:0] count;

      for (int i = 0; i < FILES; i++)
         file_span[i] = 0;

      // hold reset, then release it on a falling edge
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // ---------------- directed opening ----------------
      // read of a never-opened file: page at the end page fails
      issue_op(OP_READ,  2'd0, 20'd0,       21'd0);
      // open with the top legal length, then miss and hit on the last page
      issue_op(OP_OPEN,  2'd0, 20'd0,       21'h100000);
      issue_op(OP_READ,  2'd0, 20'hFFFFF,   21'd0);
      issue_op(OP_READ,  2'd0, 20'hFFFFF,   21'h1FFFFF);
      // oversized length is kept as given, all 21 bits
      issue_op(OP_OPEN,  2'd1, 20'hFFFFF,   21'h1FFFFF);
      // zero-length file: read fails, write past the end raises the end page
      issue_op(OP_OPEN,  2'd2, 20'd0,       21'd0);
      issue_op(OP_READ,  2'd2, 20'd0,       21'd0);
      issue_op(OP_WRITE, 2'd2, 20'hFFFFF,   21'd0);
      // fill the remaining seven slots
      for (int p = 1; p < SLOTS; p++)
         issue_op(OP_READ, 2'd1, 20'(p), 21'd0);
      // full directory: miss evicts the oldest stamp
      issue_op(OP_READ,  2'd1, 20'd100,     21'd0);
      // write invalidates a cached page, next miss takes the freed slot
      issue_op(OP_WRITE, 2'd1, 20'd3,       21'd0);
      issue_op(OP_READ,  2'd1, 20'd200,     21'd0);
      // close, then close again on an already closed file
      issue_op(OP_CLOSE, 2'd1, 20'd0,       21'd0);
      issue_op(OP_CLOSE, 2'd1, 20'd0,       21'd0);
      // reopen an open file, read the last page and the first page past it
      issue_op(OP_OPEN,  2'd0, 20'd0,       21'd5);
      issue_op(OP_READ,  2'd0, 20'd4,       21'd0);
      issue_op(OP_READ,  2'd0, 20'd5,       21'd0);
      // write to an empty file with no cached copy
      issue_op(OP_WRITE, 2'd3, 20'd0,       21'd0);

      // ---------------- random traffic ----------------
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // one stretch in four runs with no idling at all
         no_idle = ((n / 40) % 4) == 3;

         // once, mid-run: drop start and wait for every reply to drain
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(negedge clock); while (replies_owed != 0);
         end

         fid   = 2'($urandom_range(0, FILES - 1));
         span  = file_span[fid];
         reach = (span < 12) ? span : 12;
         page  = 20'($urandom_range(0, 15));
         count = 21'($urandom_range(0, 21'h1FFFFF));
         pick  = int'($urandom_range(0, 99));

         if (pick < 8) begin
            // noise: any operation, any field values
            op   = op_type'($urandom_range(0, 3));
            page = 20'($urandom_range(0, 20'hFFFFF));
         end else if (pick < 62) begin
            op = OP_READ;
            // mostly pages inside the file, sometimes just past its end
            if (reach > 0 && $urandom_range(0, 7) != 0)
               page = 20'($urandom_range(0, reach - 1));
            else
               page = 20'(span + int'($urandom_range(0, 2)));
         end else if (pick < 74) begin
            op = OP_WRITE;
            if ($urandom_range(0, 3) == 0)
               page = 20'(span);
         end else if (pick < 90) begin
            op = OP_OPEN;
            if ($urandom_range(0, 9) != 0)
               count = 21'($urandom_range(1, 16));
            else if ($urandom_range(0, 1) == 0)
               count = '0;
         end else begin
            op = OP_CLOSE;
         end

         issue_op(op, fid, page, count);
      end

      // drain: stop sending, wait for the last replies, then settle
      start <= 1'b0;
      do @(negedge clock); while (replies_owed != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && replies_owed == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
sv/lpcd_pkg.sv
sv/lpcd_front.sv
sv/lpcd_queue.sv
sv/lpcd_back.sv
sv/lru_page_cache_directory_unit.sv
sv/lpcd_checker.sv
tb/lpcd_checker.sv
tb/tb_top.sv
